// ===== rtl/core/ebs_pkg.sv =====
// Shared types and constants for the edge burst segmenter.
// No dependencies; imported by every module of the block.
package ebs_pkg;

   localparam int MAX_EDGES_DEFAULT = 1024;

   localparam int KIND_W       = 2;
   localparam int TIME_W       = 32;
   localparam int ID_W         = 32;
   localparam int KEPT_W       = 11;
   localparam int GAP_W        = 20;
   localparam int MIN_W        = 11;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 20;
   localparam int REQ_USER_W   = 8;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 112;

   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(25000);
   localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(10);

   typedef enum logic [KIND_W-1:0] {
      KIND_EDGE  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAP_THRESHOLD = 1'd0,
      CSR_MIN_EDGES     = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] time_us;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0]       span_us;
      logic [TIME_W-1:0]       start_time_us;
      logic                    truncated;
      logic [KEPT_W-1:0]       kept_edges;
      logic [ID_W-1:0]         burst_id;
   } result_type;

   typedef struct packed {
      logic                  we;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_write_type;

endpackage

// ===== rtl/core/ebs_in_reg.sv =====
// Input register stage of the edge burst segmenter.
// Depends on ebs_pkg for the item type.
module ebs_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ebs_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_fire,
   output ebs_pkg::item_type item
);
   import ebs_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign item_fire  = valid_ff && advance;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== rtl/core/ebs_core.sv =====
// Burst state, configuration registers and close/report decision.
// Depends on ebs_pkg for item, result and register-write types.
module ebs_core #(
   parameter int MAX_EDGES = ebs_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ebs_pkg::csr_write_type csr,
   input  logic                   item_fire,
   input  ebs_pkg::item_type      item,
   output logic                   res_valid,
   output ebs_pkg::result_type    res
);
   import ebs_pkg::*;

   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EDGES);

   logic [GAP_W-1:0]  gap_thr_ff, gap_thr_in;
   logic [MIN_W-1:0]  min_edges_ff, min_edges_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [TIME_W-1:0] last_edge_ff, last_edge_in;
   logic [TIME_W-1:0] first_ff, first_in;
   logic [TIME_W-1:0] last_kept_ff, last_kept_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;

   logic [TIME_W-1:0] gap;
   logic              exceeded, close, report;
   logic [CNT_W-1:0]  cnt_eff;
   logic              ovf_eff;
   logic [CMP_W-1:0]  cnt_ext;

   assign gap      = item.time_us - last_edge_ff;
   assign exceeded = (cnt_ff != '0) && (gap > TIME_W'(gap_thr_ff));
   assign cnt_ext  = CMP_W'(cnt_ff);

   always_comb begin
      gap_thr_in   = gap_thr_ff;
      min_edges_in = min_edges_ff;
      if (csr.we) begin
         case (csr.index)
            CSR_GAP_THRESHOLD: gap_thr_in   = csr.wdata[GAP_W-1:0];
            CSR_MIN_EDGES:     min_edges_in = csr.wdata[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      close        = 1'b0;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      last_edge_in = last_edge_ff;
      first_in     = first_ff;
      last_kept_in = last_kept_ff;
      case (kind_type'(item.kind))
         KIND_EDGE: begin
            close        = exceeded;
            last_edge_in = item.time_us;
         end
         KIND_TICK: close = exceeded;
         KIND_CLEAR: begin
            cnt_in       = '0;
            ovf_in       = 1'b0;
            last_edge_in = '0;
         end
         default: ;
      endcase
      cnt_eff = close ? '0 : cnt_ff;
      ovf_eff = close ? 1'b0 : ovf_ff;
      if (item.kind == KIND_EDGE) begin
         if (cnt_eff < MAX_CNT) begin
            if (cnt_eff == '0) begin
               first_in = item.time_us;
            end
            last_kept_in = item.time_us;
            cnt_in       = cnt_eff + CNT_W'(1);
            ovf_in       = ovf_eff;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (close) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
      report     = close && (cnt_ext >= CMP_W'(min_edges_ff));
      next_id_in = report ? next_id_ff + ID_W'(1) : next_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_thr_ff   <= GAP_RESET;
         min_edges_ff <= MIN_RESET;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         last_edge_ff <= '0;
         first_ff     <= '0;
         last_kept_ff <= '0;
         next_id_ff   <= ID_W'(1);
      end else begin
         gap_thr_ff   <= gap_thr_in;
         min_edges_ff <= min_edges_in;
         if (item_fire) begin
            cnt_ff       <= cnt_in;
            ovf_ff       <= ovf_in;
            last_edge_ff <= last_edge_in;
            first_ff     <= first_in;
            last_kept_ff <= last_kept_in;
            next_id_ff   <= next_id_in;
         end
      end
   end

   assign res_valid         = item_fire && report;
   assign res.burst_id      = next_id_ff;
   assign res.kept_edges    = cnt_ext[KEPT_W-1:0];
   assign res.truncated     = ovf_ff;
   assign res.start_time_us = first_ff;
   assign res.span_us       = last_kept_ff - first_ff;

endmodule

// ===== rtl/core/ebs_out_reg.sv =====
// Result register stage of the edge burst segmenter.
// Depends on ebs_pkg for the result type.
module ebs_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  ebs_pkg::result_type res,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output ebs_pkg::result_type rsp_res
);
   import ebs_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign free       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (free) begin
         valid_in = res_valid;
         if (res_valid) begin
            res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

// ===== rtl/core/edge_burst_segmenter.sv =====
// Edge burst segmenter: groups edge timestamps into bursts split by silence.
// Input register holds each item; a result is registered in the result register.
// One item per cycle unless a result stalls; burst state updates once per item.
// Reset (synchronous): no item held, no result pending, registers at defaults.
// Depends on ebs_pkg, ebs_in_reg, ebs_core and ebs_out_reg.
module edge_burst_segmenter #(
   parameter int MAX_EDGES = ebs_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ebs_pkg::REQ_DATA_W-1:0]   req_tdata,  // [31:0] time_us
   input  logic [ebs_pkg::REQ_USER_W-1:0]   req_tuser,  // [1:0] kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] burst_id, [42:32] kept_edges, [43] truncated,
   // [75:44] start_time_us, [107:76] span_us
   output logic [ebs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [ebs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ebs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ebs_pkg::*;

   item_type      req_item, item;
   csr_write_type csr;
   result_type    res, rsp_res;
   logic          free, item_fire, res_valid;

   assign req_item.kind    = req_tuser[KIND_W-1:0];
   assign req_item.time_us = req_tdata[TIME_W-1:0];
   assign csr.we           = csr_we;
   assign csr.index        = csr_index_type'(csr_index);
   assign csr.wdata        = csr_wdata;

   ebs_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (free),
      .item_fire  (item_fire),
      .item       (item)
   );

   ebs_core #(
      .MAX_EDGES (MAX_EDGES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .item_fire (item_fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   ebs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_res);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a blocked result");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> item_fire)
      else $error("result without a consumed item");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

endmodule
